FILE: hw/rtl/rmt_pkg.sv
// rmt_pkg: shared constants and types for the rotary move tracker
// no dependencies; used by the interfaces, the top level and the checker

package rmt_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int SPEED_BITS = 16;
  localparam int OP_BITS    = 3;
  localparam int DIST_BITS  = ANGLE_BITS + 1;

  localparam logic [SPEED_BITS-1:0] SPEED_RESET = SPEED_BITS'(64);
  localparam logic [ANGLE_BITS-1:0] HALF_TURN   = {1'b1, {(ANGLE_BITS-1){1'b0}}};

  typedef logic [ANGLE_BITS-1:0] angle_t;
  typedef logic [SPEED_BITS-1:0] speed_t;
  typedef logic [DIST_BITS-1:0]  dist_t;

  typedef enum logic [OP_BITS-1:0] {
    OP_TICK  = 3'd0,
    OP_MOVE  = 3'd1,
    OP_TURN  = 3'd2,
    OP_STOP  = 3'd3,
    OP_ZERO  = 3'd4
  } op_t;

endpackage

FILE: hw/rtl/rmt_if.sv
// rmt_cmd_if, rmt_res_if, rmt_cfg_if: valid/ready channels of the tracker
// depends on rmt_pkg

interface rmt_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [rmt_pkg::OP_BITS-1:0]      operation;
  logic [rmt_pkg::ANGLE_BITS-1:0]   target_angle;
  logic                             turn_ccw;

  modport source (output valid, output operation, output target_angle, output turn_ccw,
                  input ready);
  modport sink   (input valid, input operation, input target_angle, input turn_ccw,
                  output ready);
endinterface

interface rmt_res_if;
  logic                             valid;
  logic                             ready;
  logic [rmt_pkg::ANGLE_BITS-1:0]   angle_now;
  logic                             moving;
  logic                             direction_ccw;
  logic                             accepted;
  logic                             angle_changed;

  modport source (output valid, output angle_now, output moving, output direction_ccw,
                  output accepted, output angle_changed, input ready);
  modport sink   (input valid, input angle_now, input moving, input direction_ccw,
                  input accepted, input angle_changed, output ready);
endinterface

interface rmt_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rmt_pkg::SPEED_BITS-1:0]   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/rotary_move_tracker.sv
// rotary_move_tracker: angle tracker for a rotary actuator, one command per transfer
// depends on rmt_pkg and the channel interfaces in rmt_if.sv

// The block keeps the actuator angle as a 16-bit fraction of a turn and takes one
// command per cmd transfer: tick, move to target, continuous turn, stop or zero.
// Every command gives exactly one result on res, in the cycle after its transfer, held
// in an output register until res.ready takes it. A command is taken every cycle
// while the output register is empty or being emptied, so the sustained rate is one
// item per clock; the result comes from the state update and the result register.
// A move takes the shorter way round (an exact half turn goes clockwise) and ends
// on the target once the summed travel reaches the planned distance. Zero is
// refused while moving. cfg writes speed_per_tick (reset 64) and is always ready;
// write it only while no result is pending.

module rotary_move_tracker (
  input  logic       clk,
  input  logic       rst,
  rmt_cmd_if.sink    cmd,
  rmt_res_if.source  res,
  rmt_cfg_if.sink    cfg
);

  // motion state
  logic            motion_active, motion_active_next;
  rmt_pkg::angle_t angle_reg,     angle_reg_next;
  rmt_pkg::angle_t target_reg,    target_reg_next;
  logic            ccw_reg,       ccw_reg_next;
  logic            endless_reg,   endless_reg_next;
  rmt_pkg::angle_t planned_distance, planned_distance_next;
  rmt_pkg::dist_t  travelled_sum, travelled_sum_next;
  rmt_pkg::speed_t speed_per_tick;

  // result register
  logic            res_valid;
  logic            accepted_next, changed_next;
  logic            res_accepted, res_changed;

  logic            cmd_take;
  rmt_pkg::angle_t angle_adv;
  rmt_pkg::dist_t  sum;
  rmt_pkg::angle_t delta;

  // a new command goes in whenever the output register is free or being drained
  assign cmd.ready = !res_valid || res.ready;
  assign cmd_take  = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;

  // one step along the current direction, wrapping at a full turn
  assign angle_adv = ccw_reg ? (angle_reg - rmt_pkg::ANGLE_BITS'(speed_per_tick))
                             : (angle_reg + rmt_pkg::ANGLE_BITS'(speed_per_tick));
  assign sum   = travelled_sum + rmt_pkg::DIST_BITS'(speed_per_tick);
  assign delta = cmd.target_angle - angle_reg;

  always_comb begin
    motion_active_next    = motion_active;
    angle_reg_next        = angle_reg;
    target_reg_next       = target_reg;
    ccw_reg_next          = ccw_reg;
    endless_reg_next      = endless_reg;
    planned_distance_next = planned_distance;
    travelled_sum_next    = travelled_sum;
    accepted_next         = 1'b1;
    changed_next          = 1'b0;
    case (cmd.operation)
      rmt_pkg::OP_TICK: begin
        if (motion_active) begin
          if (endless_reg) begin
            angle_reg_next = angle_adv;
          end else if (sum >= {1'b0, planned_distance}) begin
            // arrived: snap onto the target and saturate the travel sum
            travelled_sum_next  = {1'b0, planned_distance};
            angle_reg_next      = target_reg;
            motion_active_next  = 1'b0;
          end else begin
            travelled_sum_next = sum;
            angle_reg_next     = angle_adv;
          end
        end
        changed_next = (angle_reg_next != angle_reg);
      end
      rmt_pkg::OP_MOVE: begin
        motion_active_next = 1'b0;
        target_reg_next    = cmd.target_angle;
        if (cmd.target_angle != angle_reg) begin
          changed_next = 1'b1;
          // longer than half a turn clockwise: go the other way
          if (delta > rmt_pkg::HALF_TURN) begin
            ccw_reg_next          = 1'b1;
            planned_distance_next = -delta;
          end else begin
            ccw_reg_next          = 1'b0;
            planned_distance_next = delta;
          end
          endless_reg_next   = 1'b0;
          travelled_sum_next = '0;
          motion_active_next = 1'b1;
        end
      end
      rmt_pkg::OP_TURN: begin
        ccw_reg_next       = cmd.turn_ccw;
        endless_reg_next   = 1'b1;
        travelled_sum_next = '0;
        motion_active_next = 1'b1;
        changed_next       = 1'b1;
      end
      rmt_pkg::OP_STOP: begin
        motion_active_next = 1'b0;
      end
      rmt_pkg::OP_ZERO: begin
        if (motion_active) begin
          accepted_next = 1'b0;
        end else begin
          angle_reg_next  = '0;
          target_reg_next = '0;
          changed_next    = 1'b1;
        end
      end
      default: begin
        // unused operation codes leave everything as it is
      end
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      motion_active    <= 1'b0;
      angle_reg        <= '0;
      target_reg       <= '0;
      ccw_reg          <= 1'b0;
      endless_reg      <= 1'b0;
      planned_distance <= '0;
      travelled_sum    <= '0;
      speed_per_tick   <= rmt_pkg::SPEED_RESET;
      res_valid        <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        speed_per_tick <= cfg.data;
      end
      if (cmd_take) begin
        motion_active    <= motion_active_next;
        angle_reg        <= angle_reg_next;
        target_reg       <= target_reg_next;
        ccw_reg          <= ccw_reg_next;
        endless_reg      <= endless_reg_next;
        planned_distance <= planned_distance_next;
        travelled_sum    <= travelled_sum_next;
        res_valid        <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result flags; the rest of the result is the state itself
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      res_accepted <= accepted_next;
      res_changed  <= changed_next;
    end
  end

  assign res.valid         = res_valid;
  assign res.angle_now     = angle_reg;
  assign res.moving        = motion_active;
  assign res.direction_ccw = ccw_reg;
  assign res.accepted      = res_accepted;
  assign res.angle_changed = res_changed;

endmodule

FILE: hw/rtl/rmt_checker.sv
// rmt_checker: port-level assertions for the rotary move tracker, bound to the top
// depends on rmt_pkg and rotary_move_tracker

module rmt_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cmd_valid,
  input logic                           cmd_ready,
  input logic                           res_valid,
  input logic                           res_ready,
  input logic [rmt_pkg::ANGLE_BITS-1:0] res_angle_now,
  input logic                           res_moving,
  input logic                           res_accepted,
  input logic                           res_angle_changed
);

  // every command transfer shows a result on the next cycle
  a_cmd_gives_res: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> res_valid)
    else $error("no result after command transfer");

  // a stalled result holds its angle
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_angle_now))
    else $error("stalled result changed");

  // zero is refused only during motion, and a refusal changes nothing
  a_refuse_moving: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_accepted |-> res_moving && !res_angle_changed)
    else $error("refusal while idle or with a change");

  // a refused zero leaves the angle where it stood
  a_refuse_angle: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && res_valid && res_ready ##1 res_valid && !res_accepted
      |-> res_angle_now == $past(res_angle_now))
    else $error("refused zero moved the angle");

endmodule

bind rotary_move_tracker rmt_checker u_rmt_checker (
  .clk               (clk),
  .rst               (rst),
  .cmd_valid         (cmd.valid),
  .cmd_ready         (cmd.ready),
  .res_valid         (res.valid),
  .res_ready         (res.ready),
  .res_angle_now     (res.angle_now),
  .res_moving        (res.moving),
  .res_accepted      (res.accepted),
  .res_angle_changed (res.angle_changed)
);

FILE: bench/rotary_move_tracker_tb.sv
// rotary_move_tracker_tb: self-checking bench for the rotary move tracker
// depends on rmt_pkg, the channel interfaces in rmt_if.sv and rotary_move_tracker

module rotary_move_tracker_tb;

  // operation codes the block must ignore
  localparam logic [rmt_pkg::OP_BITS-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [rmt_pkg::OP_BITS-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [rmt_pkg::OP_BITS-1:0] OP_SPARE_7 = 3'd7;

  localparam int RANDOM_ITEMS = 1300;

  typedef struct packed {
    rmt_pkg::angle_t angle_now;
    logic            moving;
    logic            direction_ccw;
    logic            accepted;
    logic            angle_changed;
  } track_result_t;

  // shadow copy of the tracker state plus the results still owed by the block
  class angle_tracker_shadow;
    rmt_pkg::speed_t speed;
    logic            active;
    rmt_pkg::angle_t angle;
    rmt_pkg::angle_t target;
    logic            ccw;
    logic            endless;
    rmt_pkg::dist_t  planned;
    rmt_pkg::dist_t  travelled;
    track_result_t   owed_results[$];
    int              errors;

    function new();
      speed     = rmt_pkg::SPEED_RESET;
      active    = 1'b0;
      angle     = '0;
      target    = '0;
      ccw       = 1'b0;
      endless   = 1'b0;
      planned   = '0;
      travelled = '0;
      errors    = 0;
    endfunction

    function void set_speed(rmt_pkg::speed_t v);
      speed = v;
    endfunction

    function int outstanding();
      return owed_results.size();
    endfunction

    function void step_angle();
      if (ccw) begin
        angle = angle - rmt_pkg::angle_t'(speed);
      end else begin
        angle = angle + rmt_pkg::angle_t'(speed);
      end
    endfunction

    function void run_tick();
      rmt_pkg::dist_t sum;
      if (!active) return;
      if (endless) begin
        step_angle();
        return;
      end
      sum = travelled + rmt_pkg::dist_t'(speed);
      // travel saturates at the planned distance and snaps onto the target
      if (sum >= planned) begin
        travelled = planned;
        angle     = target;
        active    = 1'b0;
      end else begin
        travelled = sum;
        step_angle();
      end
    endfunction

    function void take_command(logic [rmt_pkg::OP_BITS-1:0] op, rmt_pkg::angle_t tgt,
                               logic dir);
      track_result_t   r;
      rmt_pkg::angle_t old_angle;
      rmt_pkg::angle_t delta;
      logic            acc;
      logic            chg;
      old_angle = angle;
      acc       = 1'b1;
      chg       = 1'b0;
      case (op)
        rmt_pkg::OP_TICK: begin
          run_tick();
          chg = (angle != old_angle);
        end
        rmt_pkg::OP_MOVE: begin
          active = 1'b0;
          target = tgt;
          if (target != angle) begin
            chg   = 1'b1;
            delta = target - angle;
            // exact half turn goes clockwise
            if (delta <= rmt_pkg::HALF_TURN) begin
              ccw     = 1'b0;
              planned = rmt_pkg::dist_t'(delta);
            end else begin
              ccw     = 1'b1;
              planned = (rmt_pkg::dist_t'(1) << rmt_pkg::ANGLE_BITS)
                        - rmt_pkg::dist_t'(delta);
            end
            endless   = 1'b0;
            travelled = '0;
            active    = 1'b1;
          end
        end
        rmt_pkg::OP_TURN: begin
          ccw       = dir;
          endless   = 1'b1;
          travelled = '0;
          active    = 1'b1;
          chg       = 1'b1;
        end
        rmt_pkg::OP_STOP: begin
          active = 1'b0;
        end
        rmt_pkg::OP_ZERO: begin
          if (active) begin
            acc = 1'b0;
          end else begin
            angle  = '0;
            target = '0;
            chg    = 1'b1;
          end
        end
        default: begin
        end
      endcase
      r.angle_now     = angle;
      r.moving        = active;
      r.direction_ccw = ccw;
      r.accepted      = acc;
      r.angle_changed = chg;
      owed_results.push_back(r);
    endfunction

    function void report(string field, longint unsigned want, longint unsigned got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endfunction

    function void compare_result(track_result_t got);
      track_result_t want;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing owed, expected none, got %h", $time, got);
        return;
      end
      want = owed_results.pop_front();
      if (got.angle_now !== want.angle_now)
        report("angle_now", want.angle_now, got.angle_now);
      if (got.moving !== want.moving)
        report("moving", want.moving, got.moving);
      if (got.direction_ccw !== want.direction_ccw)
        report("direction_ccw", want.direction_ccw, got.direction_ccw);
      if (got.accepted !== want.accepted)
        report("accepted", want.accepted, got.accepted);
      if (got.angle_changed !== want.angle_changed)
        report("angle_changed", want.angle_changed, got.angle_changed);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  // when set, neither side idles
  logic quiet = 1'b0;

  // commands sent that the block acts on (spare codes are not counted)
  int live_items = 0;

  angle_tracker_shadow shadow = new();

  rmt_cmd_if cmd_ch();
  rmt_res_if res_ch();
  rmt_cfg_if cfg_ch();

  rotary_move_tracker u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side backpressure: ready is dropped about 13 percent of the time
  always @(posedge clk) begin
    res_ch.ready <= quiet || ($urandom_range(99) >= 13);
  end

  // watch all three channels; every transfer is judged on pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready)
        shadow.set_speed(cfg_ch.data);
      if (cmd_ch.valid && cmd_ch.ready)
        shadow.take_command(cmd_ch.operation, cmd_ch.target_angle, cmd_ch.turn_ccw);
      if (res_ch.valid && res_ch.ready)
        shadow.compare_result({res_ch.angle_now, res_ch.moving, res_ch.direction_ccw,
                               res_ch.accepted, res_ch.angle_changed});
    end
  end

  // one command transfer, with a random gap ahead of it unless quiet
  task automatic send_cmd(input logic [rmt_pkg::OP_BITS-1:0] op,
                          input rmt_pkg::angle_t tgt, input logic dir);
    if (!quiet && $urandom_range(99) < 13) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 30) @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.operation    <= op;
    cmd_ch.target_angle <= tgt;
    cmd_ch.turn_ccw     <= dir;
    do @(posedge clk); while (!cmd_ch.ready);
    if (op <= rmt_pkg::OP_ZERO) live_items++;
  endtask

  // hold off commands until every owed result has come back
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (shadow.outstanding() != 0) @(posedge clk);
    // margin after the last result has come back
    repeat (3) @(posedge clk);
  endtask

  // speed register write, only with the block drained
  task automatic write_speed(input rmt_pkg::speed_t v);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // targets mostly within reach of a few ticks, some at or near a half turn
  function automatic rmt_pkg::angle_t pick_target();
    int unsigned     r;
    int unsigned     span;
    rmt_pkg::angle_t off;
    r    = $urandom_range(99);
    span = ((shadow.speed == 0) ? 16 : int'(shadow.speed)) * $urandom_range(12, 1);
    if (span > 32'hFFFF) span = 32'hFFFF;
    off  = rmt_pkg::angle_t'($urandom_range(span, 0));
    if (r < 50) return $urandom_range(1) ? shadow.angle - off : shadow.angle + off;
    if (r < 65) return shadow.angle + rmt_pkg::HALF_TURN;
    if (r < 75) return shadow.angle + rmt_pkg::HALF_TURN
                       + ($urandom_range(1) ? 16'h0001 : 16'hFFFF);
    if (r < 80) return shadow.angle;
    return rmt_pkg::angle_t'($urandom);
  endfunction

  // one random stretch of traffic: mostly whole moves and turns with ticks
  task automatic random_episode();
    int unsigned r;
    int unsigned n;
    int unsigned k;
    r = $urandom_range(99);
    if (r < 45) begin
      send_cmd(rmt_pkg::OP_MOVE, pick_target(), 1'($urandom_range(1)));
      n = $urandom_range(16);
      for (k = 0; k < n; k++)
        send_cmd(rmt_pkg::OP_TICK, rmt_pkg::angle_t'($urandom), 1'($urandom_range(1)));
      if ($urandom_range(9) == 0)
        send_cmd(rmt_pkg::OP_STOP, rmt_pkg::angle_t'($urandom), 1'($urandom_range(1)));
    end else if (r < 65) begin
      send_cmd(rmt_pkg::OP_TURN, rmt_pkg::angle_t'($urandom), 1'($urandom_range(1)));
      n = $urandom_range(10);
      for (k = 0; k < n; k++)
        send_cmd(rmt_pkg::OP_TICK, rmt_pkg::angle_t'($urandom), 1'($urandom_range(1)));
      // a turn usually ends with stop, sometimes a move cuts in
      if ($urandom_range(4) != 0) begin
        send_cmd(rmt_pkg::OP_STOP, rmt_pkg::angle_t'($urandom), 1'($urandom_range(1)));
      end else begin
        send_cmd(rmt_pkg::OP_MOVE, pick_target(), 1'($urandom_range(1)));
      end
    end else if (r < 75) begin
      send_cmd(rmt_pkg::OP_ZERO, rmt_pkg::angle_t'($urandom), 1'($urandom_range(1)));
    end else if (r < 82) begin
      send_cmd(rmt_pkg::OP_STOP, rmt_pkg::angle_t'($urandom), 1'($urandom_range(1)));
    end else if (r < 87) begin
      send_cmd(rmt_pkg::OP_BITS'($urandom_range(OP_SPARE_7, OP_SPARE_5)),
               rmt_pkg::angle_t'($urandom), 1'($urandom_range(1)));
    end else begin
      send_cmd(rmt_pkg::OP_TICK, rmt_pkg::angle_t'($urandom), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    rmt_pkg::speed_t speeds[6];
    int              quota;
    int              start;
    int              p;
    logic            paused;

    // reset speed first, then slowest, half turn per tick, a stalled motor, odd values
    speeds = '{rmt_pkg::SPEED_RESET, 16'd1, 16'd32768, 16'd0, 16'd12345, 16'd3};
    quota  = RANDOM_ITEMS / 6;

    cmd_ch.valid        <= 1'b0;
    cmd_ch.operation    <= rmt_pkg::OP_TICK;
    cmd_ch.target_angle <= '0;
    cmd_ch.turn_ccw     <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.data         <= rmt_pkg::SPEED_RESET;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle no-ops, move onto current angle, exact half turn, refused zero
    send_cmd(rmt_pkg::OP_TICK, 16'hFFFF, 1'b1);
    send_cmd(rmt_pkg::OP_STOP, 16'h0000, 1'b0);
    send_cmd(rmt_pkg::OP_ZERO, 16'hFFFF, 1'b1);
    send_cmd(rmt_pkg::OP_MOVE, 16'h0000, 1'b0);
    send_cmd(rmt_pkg::OP_MOVE, rmt_pkg::HALF_TURN, 1'b1);
    send_cmd(rmt_pkg::OP_TICK, 16'h0000, 1'b0);
    send_cmd(rmt_pkg::OP_ZERO, 16'h0000, 1'b0);
    // move issued mid-motion, short way is counter-clockwise across zero
    send_cmd(rmt_pkg::OP_MOVE, 16'hFFFF, 1'b0);
    send_cmd(rmt_pkg::OP_TICK, 16'h0000, 1'b0);
    send_cmd(rmt_pkg::OP_TICK, 16'h0000, 1'b0);
    send_cmd(rmt_pkg::OP_TICK, 16'h0000, 1'b0);
    // continuous turns leave the target alone
    send_cmd(rmt_pkg::OP_TURN, 16'h1234, 1'b1);
    send_cmd(rmt_pkg::OP_TICK, 16'hFFFF, 1'b1);
    send_cmd(rmt_pkg::OP_TICK, 16'hFFFF, 1'b1);
    send_cmd(rmt_pkg::OP_TURN, 16'hFFFF, 1'b0);
    send_cmd(rmt_pkg::OP_TICK, 16'h0000, 1'b0);
    send_cmd(rmt_pkg::OP_STOP, 16'hFFFF, 1'b1);
    send_cmd(rmt_pkg::OP_ZERO, 16'h0000, 1'b0);
    // spare codes must leave everything as it was
    send_cmd(OP_SPARE_5, 16'hFFFF, 1'b1);
    send_cmd(OP_SPARE_6, 16'hFFFF, 1'b1);
    send_cmd(OP_SPARE_7, 16'hFFFF, 1'b1);
    // just past and just short of a half turn, with a small move between
    send_cmd(rmt_pkg::OP_MOVE, 16'h8001, 1'b0);
    send_cmd(rmt_pkg::OP_MOVE, 16'h0001, 1'b1);
    send_cmd(rmt_pkg::OP_MOVE, 16'h7FFF, 1'b0);

    for (p = 0; p < 6; p++) begin
      if (p != 0) write_speed(speeds[p]);
      // no idling on either side through the half-turn-per-tick phase
      quiet  = (p == 2);
      paused = 1'b0;
      start  = live_items;
      while (live_items - start < quota) begin
        random_episode();
        // once per phase, starve the block until it has handed back everything
        if (!paused && live_items - start >= quota / 2) begin
          settle();
          paused = 1'b1;
        end
      end
    end
    quiet = 1'b0;

    settle();
    repeat (8) @(posedge clk);
    if (shadow.errors == 0 && shadow.outstanding() == 0) begin
      $display("rotary_move_tracker_tb: done, clean");
    end else begin
      $display("rotary_move_tracker_tb: done, errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #400000;
    $display("rotary_move_tracker_tb: done, errors");
    $finish;
  end

endmodule
